/* rtl/window_geometry_table_assert.svh */
// Assertion macros for the checker of the window geometry table.
`ifndef WINDOW_GEOMETRY_TABLE_ASSERT_SVH
`define WINDOW_GEOMETRY_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define WGT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("window_geometry_table: assertion failed");

// Next-cycle implication, sampled on clk, quiet during reset
`define WGT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("window_geometry_table: assertion failed");

`endif

/* rtl/wgt_pkg.sv */
package wgt_pkg;

  // table sizing
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int OCC_W       = 11;

  // request codes; the spare code is a no-op
  typedef enum logic [2:0] {
    REQ_INSERT      = 3'd0,
    REQ_REMOVE      = 3'd1,
    REQ_SET_BOUNDS  = 3'd2,
    REQ_MARK_POPUP  = 3'd3,
    REQ_QUERY       = 3'd4,
    REQ_TO_SCREEN   = 3'd5,
    REQ_FROM_SCREEN = 3'd6
  } req_code_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // one stored record, 193 bits
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] handle;
    logic [31:0] bx;
    logic [31:0] by;
    logic [31:0] bw;
    logic [31:0] bh;
    logic        popup;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // result held until the output register is free
  typedef struct packed {
    status_t     status;
    logic        popup;
    logic [31:0] handle;
    logic [31:0] bx;
    logic [31:0] by;
    logic [31:0] bw;
    logic [31:0] bh;
    logic [31:0] cx;
    logic [31:0] cy;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WR_LAST,
    S_DONE
  } state_t;

endpackage

/* rtl/wgt_ram.sv */
module wgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/window_geometry_table.sv */
// Insert and the spare code go straight to the result; a lookup request scans
// the entries from index 0 and stops at the lowest match (remove then writes
// the last record into the hole), or runs through all entries on a miss.
// One request at a time: in_stall stays high until the result moves to the
// output register; the scan goes through the one RAM read port, one entry a cycle.
// Reset (synchronous, active low) clears the count and control; the record RAM
// is left as is, only entries below the count are ever used.
module window_geometry_table
  import wgt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic [31:0]        in_window_id,
  input  logic [31:0]        in_native_handle,
  input  logic signed [31:0] in_rect_x,
  input  logic signed [31:0] in_rect_y,
  input  logic signed [31:0] in_rect_width,
  input  logic signed [31:0] in_rect_height,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic               out_popup_flag,
  output logic [31:0]        out_handle_out,
  output logic signed [31:0] out_bounds_x,
  output logic signed [31:0] out_bounds_y,
  output logic signed [31:0] out_bounds_width,
  output logic signed [31:0] out_bounds_height,
  output logic signed [31:0] out_converted_x,
  output logic signed [31:0] out_converted_y,
  output logic [OCC_W-1:0]   out_occupancy
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [ADDR_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [2:0]        op_r;
  rec_t              req_rec_r;
  logic [31:0]       px_r, py_r;
  res_t              res_r, res_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  rec_t              ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  rec_t              ram_rdata;

  rec_t              in_rec;
  rec_t              mod_rec;
  logic [CNT_W-1:0]  last_idx;
  logic              full;
  logic              more;
  logic              hit;
  logic              miss;
  logic              out_free;

  logic              out_valid_r;
  res_t              out_res_r;
  logic [OCC_W-1:0]  out_occ_r;

  wgt_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // record built from the incoming beat
  always_comb begin
    in_rec.id     = in_window_id;
    in_rec.handle = in_native_handle;
    in_rec.bx     = in_rect_x;
    in_rec.by     = in_rect_y;
    in_rec.bw     = in_rect_width;
    in_rec.bh     = in_rect_height;
    in_rec.popup  = 1'b0;
  end

  assign full     = (count_r >= CNT_W'(TABLE_DEPTH));
  assign last_idx = count_r - CNT_W'(1);
  assign more     = (scan_idx_r < count_r);
  // compare stage of the scan: data belongs to the read issued last cycle
  assign hit      = (state_r == S_SCAN) && rd_vld_r && (ram_rdata.id == req_rec_r.id);
  assign miss     = (state_r == S_SCAN) && !rd_vld_r && !more;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_req_type)
            REQ_REMOVE, REQ_SET_BOUNDS, REQ_MARK_POPUP, REQ_QUERY,
            REQ_TO_SCREEN, REQ_FROM_SCREEN: state_nxt = S_SCAN;
            default:                        state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = (op_r == REQ_REMOVE) ? S_WR_LAST : S_DONE;
        end else if (miss) begin
          state_nxt = S_DONE;
        end
      end
      S_WR_LAST: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // RAM access, count and result
  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = count_r[ADDR_W-1:0];
    ram_wdata    = req_rec_r;
    ram_raddr    = scan_idx_r[ADDR_W-1:0];
    count_nxt    = count_r;
    scan_idx_nxt = scan_idx_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    hit_idx_nxt  = hit_idx_r;
    res_nxt      = res_r;
    mod_rec      = ram_rdata;
    case (state_r)
      S_IDLE: begin
        scan_idx_nxt = '0;
        if (in_valid) begin
          res_nxt        = '0;
          res_nxt.status = ST_DONE;
          case (in_req_type)
            REQ_INSERT: begin
              if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                ram_we         = 1'b1;
                ram_wdata      = in_rec;
                count_nxt      = count_r + CNT_W'(1);
                res_nxt.handle = in_rec.handle;
                res_nxt.bx     = in_rec.bx;
                res_nxt.by     = in_rec.by;
                res_nxt.bw     = in_rec.bw;
                res_nxt.bh     = in_rec.bh;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_nxt        = '0;
          res_nxt.status = ST_DONE;
          case (op_r)
            REQ_REMOVE: begin
              // fetch the last record to fill the hole
              ram_raddr   = last_idx[ADDR_W-1:0];
              count_nxt   = last_idx;
              hit_idx_nxt = rd_idx_r;
            end
            REQ_SET_BOUNDS: begin
              mod_rec.bx = req_rec_r.bx;
              mod_rec.by = req_rec_r.by;
              mod_rec.bw = req_rec_r.bw;
              mod_rec.bh = req_rec_r.bh;
              ram_we     = 1'b1;
              ram_waddr  = rd_idx_r;
              ram_wdata  = mod_rec;
            end
            REQ_MARK_POPUP: begin
              mod_rec.popup = 1'b1;
              ram_we        = 1'b1;
              ram_waddr     = rd_idx_r;
              ram_wdata     = mod_rec;
            end
            REQ_TO_SCREEN: begin
              res_nxt.cx = px_r + ram_rdata.bx;
              res_nxt.cy = py_r + ram_rdata.by;
            end
            REQ_FROM_SCREEN: begin
              res_nxt.cx = px_r - ram_rdata.bx;
              res_nxt.cy = py_r - ram_rdata.by;
            end
            default: ;
          endcase
          res_nxt.popup  = mod_rec.popup;
          res_nxt.handle = mod_rec.handle;
          res_nxt.bx     = mod_rec.bx;
          res_nxt.by     = mod_rec.by;
          res_nxt.bw     = mod_rec.bw;
          res_nxt.bh     = mod_rec.bh;
        end else begin
          // issue the next read while entries remain
          if (more) begin
            rd_vld_nxt   = 1'b1;
            rd_idx_nxt   = scan_idx_r[ADDR_W-1:0];
            scan_idx_nxt = scan_idx_r + CNT_W'(1);
          end
          if (miss) begin
            res_nxt        = '0;
            res_nxt.status = ST_NOT_FOUND;
            if (op_r == REQ_TO_SCREEN || op_r == REQ_FROM_SCREEN) begin
              res_nxt.cx = px_r;
              res_nxt.cy = py_r;
            end
          end
        end
      end
      S_WR_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = hit_idx_r;
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_vld_r <= rd_vld_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    rd_idx_r   <= rd_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    res_r      <= res_nxt;
    if (state_r == S_IDLE && in_valid) begin
      op_r      <= in_req_type;
      req_rec_r <= in_rec;
      px_r      <= in_point_x;
      py_r      <= in_point_y;
    end
    if (state_r == S_DONE && out_free) begin
      out_res_r <= res_r;
      out_occ_r <= OCC_W'(count_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_popup_flag    = out_res_r.popup;
  assign out_handle_out    = out_res_r.handle;
  assign out_bounds_x      = out_res_r.bx;
  assign out_bounds_y      = out_res_r.by;
  assign out_bounds_width  = out_res_r.bw;
  assign out_bounds_height = out_res_r.bh;
  assign out_converted_x   = out_res_r.cx;
  assign out_converted_y   = out_res_r.cy;
  assign out_occupancy     = out_occ_r;

endmodule

/* rtl/wgt_checker.sv */
`include "window_geometry_table_assert.svh"

module wgt_checker
  import wgt_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic               out_popup_flag,
  input logic [31:0]        out_handle_out,
  input logic signed [31:0] out_bounds_x,
  input logic signed [31:0] out_bounds_width,
  input logic [OCC_W-1:0]   out_occupancy
);

  // a stalled result beat holds
  `WGT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_occupancy) && $stable(out_status))

  // a refused insert only happens with the table full
  `WGT_ASSERT_NOW(a_full_occ, out_valid && out_status == ST_FULL, out_occupancy == OCC_W'(TABLE_DEPTH))

  // a refused insert reports no record
  `WGT_ASSERT_NOW(a_full_zero, out_valid && out_status == ST_FULL, out_handle_out == '0 && out_bounds_x == '0 && out_popup_flag == 1'b0)

  // a miss reports no record
  `WGT_ASSERT_NOW(a_miss_zero, out_valid && out_status == ST_NOT_FOUND, out_handle_out == '0 && out_popup_flag == 1'b0 && out_bounds_width == '0)

endmodule

bind window_geometry_table wgt_checker u_wgt_checker (.*);

/* bench/window_geometry_table_check.sv */
// Watches both channels of the window geometry table, keeps its own copy of
// the record table and compares every result beat with the oldest reply due.
module window_geometry_table_check
  import wgt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [2:0]       in_req_type,
  input  logic [31:0]      in_window_id,
  input  logic [31:0]      in_native_handle,
  input  logic [31:0]      in_rect_x,
  input  logic [31:0]      in_rect_y,
  input  logic [31:0]      in_rect_width,
  input  logic [31:0]      in_rect_height,
  input  logic [31:0]      in_point_x,
  input  logic [31:0]      in_point_y,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [1:0]       out_status,
  input  logic             out_popup_flag,
  input  logic [31:0]      out_handle_out,
  input  logic [31:0]      out_bounds_x,
  input  logic [31:0]      out_bounds_y,
  input  logic [31:0]      out_bounds_width,
  input  logic [31:0]      out_bounds_height,
  input  logic [31:0]      out_converted_x,
  input  logic [31:0]      out_converted_y,
  input  logic [OCC_W-1:0] out_occupancy,
  output int               fail_count,
  output int               pending,
  output int               held_entries,
  output int               results_seen
);

  // one reply as the table should give it
  typedef struct packed {
    status_t            status;
    logic               popup;
    logic [31:0]        handle;
    logic [31:0]        bx;
    logic [31:0]        by;
    logic [31:0]        bw;
    logic [31:0]        bh;
    logic [31:0]        cx;
    logic [31:0]        cy;
    logic [OCC_W-1:0]   occ;
  } table_reply_t;

  rec_t         window_table [TABLE_DEPTH];
  table_reply_t replies_due [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    held_entries = 0;
    results_seen = 0;
  end

  // apply one request to the table copy and work out its reply
  function automatic table_reply_t table_reply_for(
    input logic [2:0]  kind,
    input logic [31:0] wid, hnd, rx, ry, rw, rh, px, py
  );
    table_reply_t r;
    rec_t         e;
    int           hit;
    logic         touched;
    r       = '0;
    e       = '0;
    hit     = -1;
    touched = 1'b0;
    r.status = ST_DONE;
    // lowest matching index wins
    for (int i = 0; i < held_entries; i++) begin
      if (hit < 0 && window_table[i].id == wid) hit = i;
    end
    case (kind)
      REQ_INSERT: begin
        if (held_entries >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          e = '{id: wid, handle: hnd, bx: rx, by: ry, bw: rw, bh: rh, popup: 1'b0};
          window_table[held_entries] = e;
          held_entries++;
          touched = 1'b1;
        end
      end
      REQ_REMOVE, REQ_SET_BOUNDS, REQ_MARK_POPUP, REQ_QUERY,
      REQ_TO_SCREEN, REQ_FROM_SCREEN: begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
          // unknown window: point goes through untouched
          if (kind == REQ_TO_SCREEN || kind == REQ_FROM_SCREEN) begin
            r.cx = px;
            r.cy = py;
          end
        end else begin
          e       = window_table[hit];
          touched = 1'b1;
          if (kind == REQ_REMOVE) begin
            // last record fills the hole; reply shows the removed one
            window_table[hit] = window_table[held_entries - 1];
            held_entries--;
          end else begin
            case (kind)
              REQ_SET_BOUNDS: begin
                e.bx = rx;
                e.by = ry;
                e.bw = rw;
                e.bh = rh;
              end
              REQ_MARK_POPUP: e.popup = 1'b1;
              REQ_TO_SCREEN: begin
                r.cx = px + e.bx;
                r.cy = py + e.by;
              end
              REQ_FROM_SCREEN: begin
                r.cx = px - e.bx;
                r.cy = py - e.by;
              end
              default: ;
            endcase
            window_table[hit] = e;
          end
        end
      end
      default: ;  // spare code: no change
    endcase
    if (touched) begin
      r.popup  = e.popup;
      r.handle = e.handle;
      r.bx     = e.bx;
      r.by     = e.by;
      r.bw     = e.bw;
      r.bh     = e.bh;
    end
    r.occ = OCC_W'(held_entries);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("result beat %0d, %s: expected %h, got %h", results_seen, name, want, got);
    end
  endtask

  // result beat first, then the request beat of the same edge
  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      held_entries = 0;
      replies_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (replies_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result beat %0d arrived with no request outstanding", results_seen);
        end else begin
          want = replies_due.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("popup_flag", 32'(want.popup), 32'(out_popup_flag));
          check_field("handle_out", want.handle, out_handle_out);
          check_field("bounds_x", want.bx, out_bounds_x);
          check_field("bounds_y", want.by, out_bounds_y);
          check_field("bounds_width", want.bw, out_bounds_width);
          check_field("bounds_height", want.bh, out_bounds_height);
          check_field("converted_x", want.cx, out_converted_x);
          check_field("converted_y", want.cy, out_converted_y);
          check_field("occupancy", 32'(want.occ), 32'(out_occupancy));
        end
      end
      if (in_valid && !in_stall)
        replies_due.push_back(table_reply_for(in_req_type, in_window_id, in_native_handle,
                                              in_rect_x, in_rect_y, in_rect_width,
                                              in_rect_height, in_point_x, in_point_y));
    end
    pending = replies_due.size();
  end

endmodule

/* bench/window_geometry_table_test.sv */
// Stimulus and verdict for the window geometry table; checking sits in
// window_geometry_table_check.
module window_geometry_table_test;
  import wgt_pkg::*;

  localparam logic [2:0]  REQ_SPARE   = 3'd7;
  localparam logic [31:0] POS_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MIN     = 32'h8000_0000;
  localparam logic [31:0] ID_A        = 32'hFFFF_FFFF;
  localparam logic [31:0] ID_B        = 32'h0000_0000;
  localparam logic [31:0] MISS_ID     = 32'h5A5A_0001;
  localparam int          ID_POOL     = 8;
  localparam int          RAND_ITEMS  = 100;
  localparam int          SMALL_TABLE = 24;
  localparam int          HOLD_CYCLES = 300;
  localparam int          DRAIN_LIMIT = 20000;

  logic               clk              = 1'b0;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_stall;
  logic [2:0]         in_req_type      = REQ_INSERT;
  logic [31:0]        in_window_id     = '0;
  logic [31:0]        in_native_handle = '0;
  logic [31:0]        in_rect_x        = '0;
  logic [31:0]        in_rect_y        = '0;
  logic [31:0]        in_rect_width    = '0;
  logic [31:0]        in_rect_height   = '0;
  logic [31:0]        in_point_x       = '0;
  logic [31:0]        in_point_y       = '0;
  logic               out_valid;
  logic               out_stall        = 1'b0;
  logic [1:0]         out_status;
  logic               out_popup_flag;
  logic [31:0]        out_handle_out;
  logic [31:0]        out_bounds_x;
  logic [31:0]        out_bounds_y;
  logic [31:0]        out_bounds_width;
  logic [31:0]        out_bounds_height;
  logic [31:0]        out_converted_x;
  logic [31:0]        out_converted_y;
  logic [OCC_W-1:0]   out_occupancy;

  int fail_count;
  int pending;
  int held_entries;
  int results_seen;

  int          sender_idle_pct = 0;
  int          recv_stall_pct  = 0;
  int          requests_sent   = 0;
  logic        hold_req        = 1'b0;
  logic        hold_done       = 1'b0;
  logic [31:0] id_pool [ID_POOL];

  window_geometry_table dut (.*);

  window_geometry_table_check checker_i (.*);

  always #6 clk = ~clk;

  // watchdog
  initial begin
    #70_000_000;
    $display("FAIL window_geometry_table");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // one request beat; valid stays high afterwards until the next beat or a pause
  task automatic send_request(input logic [2:0] kind,
                              input logic [31:0] wid, hnd, rx, ry, rw, rh, px, py);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_req_type      = kind;
    in_window_id     = wid;
    in_native_handle = hnd;
    in_rect_x        = rx;
    in_rect_y        = ry;
    in_rect_width    = rw;
    in_rect_height   = rh;
    in_point_x       = px;
    in_point_y       = py;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    @(negedge clk);
  endtask

  // field value with a bias towards the Q16.16 extremes
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return POS_MAX;
      1:       return NEG_MIN;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_id();
    if ($urandom_range(99) < 85) return id_pool[$urandom_range(ID_POOL - 1)];
    return $urandom();
  endfunction

  // mostly hits on a small set of ids; the table is kept small
  task automatic send_random_request();
    logic [2:0] kind;
    int         roll;
    roll = $urandom_range(99);
    if (roll < 18)      kind = (held_entries < SMALL_TABLE) ? REQ_INSERT : REQ_REMOVE;
    else if (roll < 32) kind = REQ_REMOVE;
    else if (roll < 44) kind = REQ_SET_BOUNDS;
    else if (roll < 54) kind = REQ_MARK_POPUP;
    else if (roll < 68) kind = REQ_QUERY;
    else if (roll < 82) kind = REQ_TO_SCREEN;
    else if (roll < 96) kind = REQ_FROM_SCREEN;
    else                kind = REQ_SPARE;
    send_request(kind, pick_id(), $urandom(), pick_word(), pick_word(), pick_word(),
                 pick_word(), pick_word(), pick_word());
  endtask

  initial begin
    int          waited;
    id_pool[0] = ID_A;
    id_pool[1] = ID_B;
    id_pool[2] = NEG_MIN;
    id_pool[3] = POS_MAX;
    for (int i = 4; i < ID_POOL; i++) id_pool[i] = $urandom();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, spare code, duplicates, wrap-around, hole filling
    send_request(REQ_QUERY, MISS_ID, '0, '0, '0, '0, '0, '0, '0);
    send_request(REQ_TO_SCREEN, MISS_ID, '0, '0, '0, '0, '0, POS_MAX, NEG_MIN);
    send_request(REQ_FROM_SCREEN, ID_A, '0, '0, '0, '0, '0, '1, '0);
    send_request(REQ_REMOVE, ID_B, '0, '0, '0, '0, '0, '0, '0);
    send_request(REQ_SPARE, ID_A, '1, '1, '1, '1, '1, '1, '1);
    send_request(REQ_INSERT, ID_A, '1, POS_MAX, NEG_MIN, '1, '0, '1, '1);
    send_request(REQ_INSERT, ID_B, '0, '0, '0, '0, '0, '0, '0);
    send_request(REQ_INSERT, ID_A, 32'h1234_5678, 32'h0001_0000, 32'hFFFF_0000,
                 32'h0064_0000, 32'h0032_8000, '0, '0);
    send_request(REQ_QUERY, ID_A, '0, '0, '0, '0, '0, '0, '0);
    send_request(REQ_SET_BOUNDS, ID_A, '0, NEG_MIN, POS_MAX, POS_MAX, NEG_MIN, '0, '0);
    send_request(REQ_MARK_POPUP, ID_A, '0, '0, '0, '0, '0, '0, '0);
    send_request(REQ_TO_SCREEN, ID_A, '0, '0, '0, '0, '0, POS_MAX, POS_MAX);
    send_request(REQ_FROM_SCREEN, ID_A, '0, '0, '0, '0, '0, NEG_MIN, '0);
    send_request(REQ_SET_BOUNDS, ID_B, '0, 32'h0010_8000, 32'hFFF0_0000, '1, POS_MAX,
                 '0, '0);
    send_request(REQ_REMOVE, ID_A, '0, '0, '0, '0, '0, '0, '0);
    send_request(REQ_QUERY, ID_A, '0, '0, '0, '0, '0, '0, '0);
    send_request(REQ_SPARE, ID_B, '0, '0, '0, '0, '0, '0, '0);
    send_request(REQ_REMOVE, ID_B, '0, '0, '0, '0, '0, '0, '0);
    send_request(REQ_REMOVE, ID_A, '0, '0, '0, '0, '0, '0, '0);
    send_request(REQ_QUERY, ID_A, '0, '0, '0, '0, '0, '0, '0);

    // random: no idling, with one long output hold-off part way through
    repeat (RAND_ITEMS / 2) send_random_request();
    hold_req = 1'b1;
    repeat (RAND_ITEMS / 2) send_random_request();

    sender_idle_pct = 61;
    recv_stall_pct  = 0;
    repeat (RAND_ITEMS) send_random_request();

    sender_idle_pct = 0;
    recv_stall_pct  = 61;
    repeat (RAND_ITEMS) send_random_request();

    sender_idle_pct = 13;
    recv_stall_pct  = 13;
    repeat (RAND_ITEMS) send_random_request();

    // drain
    in_valid = 1'b0;
    waited   = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    $display("covered %0d requests: directed cases, four idling mixes and a %0d-cycle output",
             requests_sent, HOLD_CYCLES);
    $display("hold-off on a table of up to %0d entries; %0d result beats checked",
             SMALL_TABLE, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS window_geometry_table");
    end else begin
      $display("FAIL window_geometry_table");
    end
    $finish;
  end

endmodule
